// ===== sv/lfu_pkg.sv =====
// Shared constants and types for the LFU min-heap evictor.
package lfu_pkg;
  localparam int TagBits = 32;
  localparam int CountBits = 16;
  localparam int Capacity = 255;
  localparam int AddrBits = 8;
  localparam int EntryBits = TagBits + CountBits;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpAccess = 2'd1;
  localparam logic [1:0] OpPop = 2'd2;

  typedef struct packed {
    logic [TagBits-1:0] tag;
    logic [CountBits-1:0] count;
  } entry_t;
endpackage

// ===== sv/lfu_min_heap_evictor_unit.sv =====
// Top level of the LFU min-heap evictor.
// Usage: items enter on the s_axis channel: tdata[1:0] is the operation
// (insert, access, pop), tdata[33:2] the tag. Every item gives exactly one
// result on m_axis. One item is handled at a time; s_axis_tready is high
// only while the block is idle and no result is pending, so the next item
// is taken at the earliest in the cycle after the previous result has left.
// The heap lives in one RAM of 256 entries with a registered read;
// every step of search or sift is a read followed by a compare.
// Latency to m_axis_tvalid grows with the levels climbed (insert) and sunk
// (pop, full insert, access hit), and for access with the slot searched;
// the search sets the worst case, at 255 entries.
// Reset clears the entry count; heap contents need no clearing since only
// slots up to the count are read. When the receiver stalls the result is
// held in the output register and no new item is taken until it leaves.
module lfu_min_heap_evictor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation[1:0], tag[33:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // evicted[0], evicted_tag[32:1], evicted_count[48:33], hit[49],
  // empty_error[50], occupancy[58:51], zero fill
  output logic [63:0] m_axis_tdata
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRemRd = 4'd1;   // read of last slot issued
  localparam logic [3:0] StRemLast = 4'd2;
  localparam logic [3:0] StSdRdL = 4'd3;   // sift down: left child read issued
  localparam logic [3:0] StSdRdR = 4'd4;
  localparam logic [3:0] StSdCmp = 4'd5;
  localparam logic [3:0] StSuRd = 4'd6;    // sift up: parent read issued
  localparam logic [3:0] StSuCmp = 4'd7;
  localparam logic [3:0] StSrRd = 4'd8;    // search
  localparam logic [3:0] StSrCmp = 4'd9;
  localparam logic [3:0] StDone = 4'd10;
  localparam logic [3:0] StRemRoot = 4'd11;

  logic [3:0] state;
  logic [1:0] op;
  logic [lfu_pkg::TagBits-1:0] tag;
  logic [lfu_pkg::AddrBits-1:0] total;
  logic [lfu_pkg::AddrBits-1:0] pos;
  logic [lfu_pkg::AddrBits:0] child;
  lfu_pkg::entry_t item, left_e, gone;
  logic evicted, hit, empty_err;

  logic we;
  logic [lfu_pkg::AddrBits-1:0] waddr, raddr;
  lfu_pkg::entry_t wdata, rdata;

  lfu_ram #(.Width(lfu_pkg::EntryBits), .Depth(256)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [lfu_pkg::AddrBits:0] lchild;
  assign lchild = {pos, 1'b0};

  // sift down: right child wins only when strictly smaller than the left
  logic sd_right, sd_move, su_move;
  lfu_pkg::entry_t sd_cand;
  logic [lfu_pkg::AddrBits-1:0] sd_addr;
  assign sd_right = child[0] && (left_e.count > rdata.count);
  assign sd_cand = sd_right ? rdata : left_e;
  assign sd_move = (child != '0) && (item.count > sd_cand.count);
  assign sd_addr = {child[lfu_pkg::AddrBits-1:1], sd_right};
  assign su_move = (pos > 8'd1) && (rdata.count > 16'd1);

  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = item;
    raddr = pos;
    case (state)
      StIdle: raddr = 8'd1;
      StRemRd: raddr = total;
      StSdRdL: raddr = lchild[lfu_pkg::AddrBits-1:0];
      StSdRdR: raddr = lchild[lfu_pkg::AddrBits-1:0] | 8'd1;
      StSuRd: raddr = {1'b0, pos[lfu_pkg::AddrBits-1:1]};
      default: raddr = pos;
    endcase
    if (state == StSdCmp) begin
      we = 1'b1;
      if (sd_move) begin
        wdata = sd_cand;
      end
    end
    if (state == StSuCmp) begin
      we = 1'b1;
      if (su_move) begin
        wdata = rdata;
      end
    end
  end

  assign s_axis_tready = (state == StIdle) && !m_axis_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      total <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op <= s_axis_tdata[1:0];
            tag <= s_axis_tdata[33:2];
            evicted <= 1'b0;
            hit <= 1'b0;
            empty_err <= 1'b0;
            gone <= '0;
            case (s_axis_tdata[1:0])
              lfu_pkg::OpInsert:
                state <= (total >= 8'(lfu_pkg::Capacity)) ? StRemRoot : StSuRd;
              lfu_pkg::OpAccess: state <= (total == '0) ? StDone : StSrRd;
              lfu_pkg::OpPop: begin
                if (total == '0) begin
                  empty_err <= 1'b1;
                  state <= StDone;
                end else begin
                  state <= StRemRoot;
                end
              end
              default: state <= StDone;
            endcase
            if (s_axis_tdata[1:0] == lfu_pkg::OpInsert && total < 8'(lfu_pkg::Capacity))
              begin
              total <= total + 8'd1;
              pos <= total + 8'd1;
              item <= '{tag: s_axis_tdata[33:2], count: 16'd1};
            end else begin
              pos <= 8'd1;
            end
          end
        end
        StRemRoot: begin
          // root read data arrives now; the read of the last slot is issued in StRemRd
          gone <= rdata;
          evicted <= 1'b1;
          state <= StRemRd;
        end
        StRemRd: state <= StRemLast;
        StRemLast: begin
          pos <= 8'd1;
          if (total == 8'd1) begin
            if (op == lfu_pkg::OpInsert) begin
              // heap emptied; the new tag goes straight into the root
              item <= '{tag: tag, count: 16'd1};
              state <= StSuRd;
            end else begin
              total <= '0;
              state <= StDone;
            end
          end else begin
            item <= rdata;
            total <= total - 8'd1;
            state <= StSdRdL;
          end
        end
        StSdRdL: begin
          if (lchild > {1'b0, total}) begin
            state <= StSdCmp;
            child <= '0;
          end else begin
            state <= StSdRdR;
            child <= lchild;
          end
        end
        StSdRdR: begin
          left_e <= rdata;
          state <= StSdCmp;
          if (child != {1'b0, total}) child <= child | 9'd1;
        end
        StSdCmp: begin
          if (sd_move) begin
            pos <= sd_addr;
            state <= StSdRdL;
          end else if (op == lfu_pkg::OpInsert) begin
            // eviction done; sift the new tag up from the freed last slot
            total <= total + 8'd1;
            pos <= total + 8'd1;
            item <= '{tag: tag, count: 16'd1};
            state <= StSuRd;
          end else begin
            state <= StDone;
          end
        end
        StSuRd: state <= StSuCmp;
        StSuCmp: begin
          if (su_move) begin
            pos <= {1'b0, pos[lfu_pkg::AddrBits-1:1]};
            state <= StSuRd;
          end else begin
            state <= StDone;
          end
        end
        StSrRd: state <= StSrCmp;
        StSrCmp: begin
          if (rdata.tag == tag) begin
            hit <= 1'b1;
            item <= '{tag: rdata.tag,
                      count: (rdata.count < lfu_pkg::CountMax) ? rdata.count + 16'd1
                                                               : rdata.count};
            state <= StSdRdL;
          end else if (pos == total) begin
            state <= StDone;
          end else begin
            pos <= pos + 8'd1;
            state <= StSrRd;
          end
        end
        StDone: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {5'd0, total, empty_err, hit, gone.count, gone.tag, evicted};
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= 8'(lfu_pkg::Capacity))
    else $error("entry count above capacity");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == StIdle)
    else $error("ready outside idle");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == StDone |=> m_axis_tvalid)
    else $error("result not shown");
  a_pop_err: assert property (@(posedge clk) disable iff (rst)
    state == StDone |-> !(evicted && empty_err))
    else $error("evict with empty error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

// ===== sv/lfu_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
